### rtl/slrt_pkg.sv
// Package for the sequence loss and reorder tracker.
// Holds the field widths, the default window depth, the verdict codes
// and the result item record. No dependencies.
`default_nettype none

package slrt_pkg;

   localparam int SEQ_W          = 32;
   localparam int CNT_W          = 32;
   localparam int WINDOW_DEFAULT = 64;

   typedef enum logic [1:0] {
      VERDICT_IN_ORDER  = 2'd0,
      VERDICT_RECOVERED = 2'd1,
      VERDICT_STALE     = 2'd2,
      VERDICT_GAP       = 2'd3
   } verdict_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [SEQ_W-1:0]  expected_before;
      logic [SEQ_W-1:0]  gap_size;
      logic [CNT_W-1:0]  received_total;
      logic [CNT_W-1:0]  lost_total;
      logic [CNT_W-1:0]  reordered_total;
   } result_type;

endpackage

`default_nettype wire

### rtl/sequence_loss_reorder_tracker.sv
// Top level of the sequence loss and reorder tracker: state update,
// result register and skid register. Depends on slrt_pkg.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall  seq_number
//   rsp_     out        rsp_valid/rsp_stall  verdict, expected_before, gap_size,
//                                            received_total, lost_total,
//                                            reordered_total
//
// One item per cycle while req_stall is low. The state and the result are
// computed in the cycle in which an item is accepted, then registered.
// Synchronous reset clears the state, the counters and both output stages;
// req_stall is held high while reset is asserted.
// The result register is backed by one skid register: req_stall rises
// only when both hold items or in reset; outside reset it comes from a flop.
`default_nettype none

module sequence_loss_reorder_tracker #(
   parameter int WINDOW = slrt_pkg::WINDOW_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [slrt_pkg::SEQ_W-1:0]   req_seq_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_verdict,
   output logic [slrt_pkg::SEQ_W-1:0]        rsp_expected_before,
   output logic [slrt_pkg::SEQ_W-1:0]        rsp_gap_size,
   output logic [slrt_pkg::CNT_W-1:0]        rsp_received_total,
   output logic [slrt_pkg::CNT_W-1:0]        rsp_lost_total,
   output logic [slrt_pkg::CNT_W-1:0]        rsp_reordered_total
);

   localparam int SEQ_W = slrt_pkg::SEQ_W;
   localparam int CNT_W = slrt_pkg::CNT_W;
   localparam int SHW   = $clog2(WINDOW);

   logic [SEQ_W-1:0]   expected_ff, expected_in;
   logic [WINDOW-1:0]  bitmap_ff, bitmap_in;
   logic [CNT_W-1:0]   received_ff, received_in;
   logic [CNT_W-1:0]   lost_ff, lost_in;
   logic [CNT_W-1:0]   reorder_ff, reorder_in;

   slrt_pkg::result_type result_in;
   slrt_pkg::result_type out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;

   logic accept;
   logic take_out;

   assign req_stall = skid_valid_ff | reset;
   assign accept    = req_valid & ~req_stall;
   assign take_out  = out_valid_ff & ~rsp_stall;

   // Per-item state update.
   always_comb begin
      logic [SEQ_W-1:0]   gap;
      logic [SEQ_W:0]     shift_k;
      logic [SEQ_W-1:0]   lag;
      logic [SHW-1:0]     hi;
      logic [WINDOW-1:0]  shifted;
      logic [WINDOW-1:0]  mark;
      logic [CNT_W:0]     rcv_sum;
      logic [CNT_W:0]     lost_sum;
      logic [CNT_W:0]     reo_sum;
      slrt_pkg::verdict_type verdict;

      gap      = req_seq_number - expected_ff;
      shift_k  = {1'b0, gap} + {{SEQ_W{1'b0}}, 1'b1};
      lag      = expected_ff - {{(SEQ_W-1){1'b0}}, 1'b1} - req_seq_number;
      hi       = (gap < SEQ_W'(WINDOW - 1)) ? gap[SHW-1:0] : SHW'(WINDOW - 1);
      shifted  = (shift_k >= (SEQ_W+1)'(WINDOW)) ? '0 : (bitmap_ff << shift_k[SHW-1:0]);
      mark     = {WINDOW{1'b1}} >> (SHW'(WINDOW - 1) - hi);
      mark[0]  = 1'b0;
      rcv_sum  = {1'b0, received_ff} + {{CNT_W{1'b0}}, 1'b1};
      lost_sum = {1'b0, lost_ff} + {1'b0, gap};
      reo_sum  = {1'b0, reorder_ff} + {{CNT_W{1'b0}}, 1'b1};

      expected_in = expected_ff;
      bitmap_in   = bitmap_ff;
      lost_in     = lost_ff;
      reorder_in  = reorder_ff;
      received_in = rcv_sum[CNT_W] ? {CNT_W{1'b1}} : rcv_sum[CNT_W-1:0];
      verdict     = slrt_pkg::VERDICT_STALE;

      if (req_seq_number == expected_ff) begin
         verdict     = slrt_pkg::VERDICT_IN_ORDER;
         bitmap_in   = bitmap_ff << 1;
         expected_in = expected_ff + {{(SEQ_W-1){1'b0}}, 1'b1};
      end else if (req_seq_number > expected_ff) begin
         verdict     = slrt_pkg::VERDICT_GAP;
         bitmap_in   = shifted | mark;
         lost_in     = lost_sum[CNT_W] ? {CNT_W{1'b1}} : lost_sum[CNT_W-1:0];
         expected_in = req_seq_number + {{(SEQ_W-1){1'b0}}, 1'b1};
      end else if ((lag < SEQ_W'(WINDOW)) && bitmap_ff[lag[SHW-1:0]]) begin
         // A late arrival still marked missing is taken off the lost list.
         verdict                  = slrt_pkg::VERDICT_RECOVERED;
         bitmap_in[lag[SHW-1:0]]  = 1'b0;
         lost_in    = (lost_ff != '0) ? lost_ff - {{(CNT_W-1){1'b0}}, 1'b1} : lost_ff;
         reorder_in = reo_sum[CNT_W] ? {CNT_W{1'b1}} : reo_sum[CNT_W-1:0];
      end

      result_in.verdict         = verdict;
      result_in.expected_before = expected_ff;
      result_in.gap_size        = (verdict == slrt_pkg::VERDICT_GAP) ? gap : '0;
      result_in.received_total  = received_in;
      result_in.lost_total      = lost_in;
      result_in.reordered_total = reorder_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         bitmap_ff   <= '0;
         received_ff <= '0;
         lost_ff     <= '0;
         reorder_ff  <= '0;
      end else if (accept) begin
         expected_ff <= expected_in;
         bitmap_ff   <= bitmap_in;
         received_ff <= received_in;
         lost_ff     <= lost_in;
         reorder_ff  <= reorder_in;
      end
   end

   // The skid register only fills while the result register is held, and
   // it always drains into the result register before new items do.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= result_in;
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_ff       <= result_in;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_verdict         = out_ff.verdict;
   assign rsp_expected_before = out_ff.expected_before;
   assign rsp_gap_size        = out_ff.gap_size;
   assign rsp_received_total  = out_ff.received_total;
   assign rsp_lost_total      = out_ff.lost_total;
   assign rsp_reordered_total = out_ff.reordered_total;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the result register is empty");

   a_in_order_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_seq_number == expected_ff) |=>
         (expected_ff == $past(expected_ff) + 32'd1))
      else $error("in-order item did not advance the expected number by one");

   a_gap_jump: assert property (@(posedge clock) disable iff (reset)
      (accept && req_seq_number > expected_ff) |=>
         (expected_ff == $past(req_seq_number) + 32'd1 && !bitmap_ff[0]))
      else $error("gap item did not move the expected number past itself");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(expected_ff) && $stable(bitmap_ff) && $stable(received_ff)))
      else $error("tracker state changed without an accepted item");
`endif

endmodule

`default_nettype wire

### bench/sequence_loss_reorder_tracker_tb.sv
// Testbench for sequence_loss_reorder_tracker: a directed table, then random
// sequence numbers, results checked against given rows or a behavioral model.
// Depends on slrt_pkg and the tracker RTL only.
`timescale 1ns / 100ps

module sequence_loss_reorder_tracker_tb;

   localparam int SEQ_W        = slrt_pkg::SEQ_W;
   localparam int CNT_W        = slrt_pkg::CNT_W;
   localparam int WIN          = slrt_pkg::WINDOW_DEFAULT;
   localparam int NDIR         = 25;
   localparam int RANDOM_ITEMS = 1925;

   typedef struct {
      logic [SEQ_W-1:0]      seq;
      bit                    given;
      slrt_pkg::verdict_type verdict;
      logic [SEQ_W-1:0]      prior;
      logic [SEQ_W-1:0]      gap;
      logic [CNT_W-1:0]      rcvd;
      logic [CNT_W-1:0]      lost;
      logic [CNT_W-1:0]      reord;
   } seq_row_type;

   // Rows with given set carry a result worked out by hand; the rest are
   // checked against the tracker model.
   seq_row_type directed_rows [NDIR] = '{
      '{32'd0, 1'b1, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0},
      '{32'd1, 1'b1, slrt_pkg::VERDICT_IN_ORDER, 32'd1, 32'd0, 32'd2, 32'd0, 32'd0},
      '{32'd5, 1'b1, slrt_pkg::VERDICT_GAP, 32'd2, 32'd3, 32'd3, 32'd3, 32'd0},
      '{32'd3, 1'b1, slrt_pkg::VERDICT_RECOVERED, 32'd6, 32'd0, 32'd4, 32'd2, 32'd1},
      '{32'd3, 1'b1, slrt_pkg::VERDICT_STALE, 32'd6, 32'd0, 32'd5, 32'd2, 32'd1},
      '{32'd0, 1'b1, slrt_pkg::VERDICT_STALE, 32'd6, 32'd0, 32'd6, 32'd2, 32'd1},
      '{32'd6, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd200, 1'b1, slrt_pkg::VERDICT_GAP, 32'd7, 32'd193, 32'd8, 32'd195, 32'd1},
      '{32'd137, 1'b1, slrt_pkg::VERDICT_RECOVERED, 32'd201, 32'd0, 32'd9, 32'd194, 32'd2},
      '{32'd136, 1'b1, slrt_pkg::VERDICT_STALE, 32'd201, 32'd0, 32'd10, 32'd194, 32'd2},
      '{32'd199, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd8, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'hFFFFFFFF, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'hFFFFFFFE, 1'b1, slrt_pkg::VERDICT_GAP,
        32'd0, 32'hFFFFFFFE, 32'd14, 32'hFFFFFFFF, 32'd3},
      '{32'hFFFFFFFD, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'hFFFFFFFF, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd0, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd2, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd1, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd66, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd3, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'h80000000, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'h7FFFFFFF, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'h55555555, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{32'hAAAAAAAA, 1'b0, slrt_pkg::VERDICT_IN_ORDER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [SEQ_W-1:0] req_seq_number;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [1:0]       rsp_verdict;
   logic [SEQ_W-1:0] rsp_expected_before;
   logic [SEQ_W-1:0] rsp_gap_size;
   logic [CNT_W-1:0] rsp_received_total;
   logic [CNT_W-1:0] rsp_lost_total;
   logic [CNT_W-1:0] rsp_reordered_total;

   // Tracker model state.
   logic [SEQ_W-1:0] trk_next;
   logic [WIN-1:0]   trk_missing;
   logic [CNT_W-1:0] trk_received;
   logic [CNT_W-1:0] trk_lost;
   logic [CNT_W-1:0] trk_reordered;

   slrt_pkg::result_type results_due [$];
   int                   errors;
   int                   verdict_tally [4];
   bit                   calm;

   sequence_loss_reorder_tracker uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_seq_number      (req_seq_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_expected_before (rsp_expected_before),
      .rsp_gap_size        (rsp_gap_size),
      .rsp_received_total  (rsp_received_total),
      .rsp_lost_total      (rsp_lost_total),
      .rsp_reordered_total (rsp_reordered_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for the tracker.");
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   endfunction

   // Updates the tracker model with one received number and returns the
   // result item that the block should produce for it.
   function automatic slrt_pkg::result_type track_sequence(input logic [SEQ_W-1:0] seq);
      slrt_pkg::result_type r;
      logic [SEQ_W:0]       span;
      logic [SEQ_W-1:0]     lag;
      int unsigned          top;
      int unsigned          i;
      r.verdict         = slrt_pkg::VERDICT_STALE;
      r.expected_before = trk_next;
      r.gap_size        = '0;
      trk_received      = sat_add(trk_received, 1);
      if (seq == trk_next) begin
         r.verdict   = slrt_pkg::VERDICT_IN_ORDER;
         trk_missing = trk_missing << 1;
         trk_next    = trk_next + 1;
      end else if (seq > trk_next) begin
         r.verdict   = slrt_pkg::VERDICT_GAP;
         r.gap_size  = seq - trk_next;
         span        = {1'b0, r.gap_size} + 1;
         trk_missing = (span >= WIN) ? '0 : trk_missing << span;
         top         = (r.gap_size < WIN - 1) ? r.gap_size : WIN - 1;
         for (i = 1; i <= top; i++)
            trk_missing[i] = 1'b1;
         trk_lost = sat_add(trk_lost, r.gap_size);
         trk_next = seq + 1;
      end else begin
         lag = trk_next - 1 - seq;
         if (lag < WIN && trk_missing[lag]) begin
            trk_missing[lag] = 1'b0;
            if (trk_lost != 0)
               trk_lost = trk_lost - 1;
            trk_reordered = sat_add(trk_reordered, 1);
            r.verdict     = slrt_pkg::VERDICT_RECOVERED;
         end
      end
      r.received_total  = trk_received;
      r.lost_total      = trk_lost;
      r.reordered_total = trk_reordered;
      return r;
   endfunction

   // Mostly numbers near the expected one, with late arrivals aimed at the
   // numbers still marked missing. Far jumps, which soon saturate the lost
   // count, are allowed only late in the run.
   function automatic logic [SEQ_W-1:0] pick_seq(input bit far_jumps);
      int unsigned roll;
      int unsigned start;
      int unsigned k;
      roll = $urandom_range(99);
      if (roll < 30)
         return trk_next;
      if (roll < 52)
         return trk_next + $urandom_range(1, 8);
      if (roll < 64)
         return trk_next + $urandom_range(9, 2 * WIN + 10);
      if (roll < 84) begin
         start = $urandom_range(WIN - 1);
         for (k = 0; k < WIN; k++)
            if (trk_missing[(start + k) % WIN])
               return trk_next - 1 - (start + k) % WIN;
         return trk_next - 1 - start;
      end
      if (roll < 94 || !far_jumps)
         return trk_next - 1 - $urandom_range(0, 2 * WIN);
      if (roll < 98)
         return $urandom;
      return 32'hFFFFFFFF - $urandom_range(0, 2);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= 40)
         $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
   endtask

   // Presents one number, holds it until accepted, then files the result due.
   task automatic send_seq(input logic [SEQ_W-1:0] seq, input bit given,
                           input slrt_pkg::result_type typed_res);
      slrt_pkg::result_type due;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_seq_number <= seq;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      due = track_sequence(seq);
      results_due.insert(results_due.size(), given ? typed_res : due);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 11);
   end

   always @(posedge clock) begin
      slrt_pkg::result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch("unrequested result", rsp_expected_before, '0);
         end else begin
            due = results_due.pop_front();
            verdict_tally[due.verdict]++;
            if (rsp_verdict !== due.verdict)
               report_mismatch("verdict", 32'(rsp_verdict), 32'(due.verdict));
            if (rsp_expected_before !== due.expected_before)
               report_mismatch("expected_before", rsp_expected_before, due.expected_before);
            if (rsp_gap_size !== due.gap_size)
               report_mismatch("gap_size", rsp_gap_size, due.gap_size);
            if (rsp_received_total !== due.received_total)
               report_mismatch("received_total", rsp_received_total, due.received_total);
            if (rsp_lost_total !== due.lost_total)
               report_mismatch("lost_total", rsp_lost_total, due.lost_total);
            if (rsp_reordered_total !== due.reordered_total)
               report_mismatch("reordered_total", rsp_reordered_total, due.reordered_total);
         end
      end
   end

   initial begin
      slrt_pkg::result_type typed_res;
      int                   n;
      errors         = 0;
      verdict_tally  = '{0, 0, 0, 0};
      calm           = 1'b0;
      trk_next       = '0;
      trk_missing    = '0;
      trk_received   = '0;
      trk_lost       = '0;
      trk_reordered  = '0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_seq_number = '0;
      rsp_stall      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < NDIR; n++) begin
         typed_res.verdict         = directed_rows[n].verdict;
         typed_res.expected_before = directed_rows[n].prior;
         typed_res.gap_size        = directed_rows[n].gap;
         typed_res.received_total  = directed_rows[n].rcvd;
         typed_res.lost_total      = directed_rows[n].lost;
         typed_res.reordered_total = directed_rows[n].reord;
         send_seq(directed_rows[n].seq, directed_rows[n].given, typed_res);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // A stretch in the middle runs with neither side idling.
         calm = (n >= 500 && n < 800);
         send_seq(pick_seq(n >= 1200), 1'b0, typed_res);
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (results_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d items: %0d in order, %0d gaps, %0d recovered, %0d ignored.",
               NDIR + RANDOM_ITEMS, verdict_tally[slrt_pkg::VERDICT_IN_ORDER],
               verdict_tally[slrt_pkg::VERDICT_GAP],
               verdict_tally[slrt_pkg::VERDICT_RECOVERED],
               verdict_tally[slrt_pkg::VERDICT_STALE]);
      $display("Included window edges, wide gaps, expected-number wrap %s",
               "and lost-count saturation.");
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sequence_loss_reorder_tracker.f
rtl/slrt_pkg.sv
rtl/sequence_loss_reorder_tracker.sv
bench/sequence_loss_reorder_tracker_tb.sv
